// ===== rtl/das_pkg.sv =====
// shared constants, types and the cordic arctangent table of the dihedral angle stream
package das_pkg;

  // default configuration
  localparam int COORD_WIDTH_DEF     = 24;
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  // fixed datapath sizes
  localparam int QDEG         = 20;
  localparam int CORDIC_STEPS = 27;
  localparam int MAG_BITS     = 30;
  localparam int WIDE_W       = 64;
  localparam int MUL_W        = 32;
  localparam int CRD_W        = 34;
  localparam int ZW           = 32;
  localparam int OUT_W        = 16;
  localparam int STRIDE_W     = 4;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;

  // register map (index of a register, taken from the word address)
  localparam logic REG_WINDOW_STRIDE = 1'b0;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 4'd1;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [CRD_W-1:0]  crd_t;
  typedef logic signed [ZW-1:0]     ang_t;

  localparam wide_t MAG_LIM = 64'sd1 <<< MAG_BITS;

  // arctangent of 2^-i in degrees, q20
  function automatic ang_t atan_q20(input logic [4:0] i);
    ang_t v;
    unique case (i)
      5'd0:  v = 32'sd47185920;
      5'd1:  v = 32'sd27855475;
      5'd2:  v = 32'sd14718068;
      5'd3:  v = 32'sd7471121;
      5'd4:  v = 32'sd3750058;
      5'd5:  v = 32'sd1876857;
      5'd6:  v = 32'sd938658;
      5'd7:  v = 32'sd469357;
      5'd8:  v = 32'sd234682;
      5'd9:  v = 32'sd117342;
      5'd10: v = 32'sd58671;
      5'd11: v = 32'sd29335;
      5'd12: v = 32'sd14668;
      5'd13: v = 32'sd7334;
      5'd14: v = 32'sd3667;
      5'd15: v = 32'sd1833;
      5'd16: v = 32'sd917;
      5'd17: v = 32'sd458;
      5'd18: v = 32'sd229;
      5'd19: v = 32'sd115;
      5'd20: v = 32'sd57;
      5'd21: v = 32'sd29;
      5'd22: v = 32'sd14;
      5'd23: v = 32'sd7;
      5'd24: v = 32'sd4;
      5'd25: v = 32'sd2;
      5'd26: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/das_front.sv =====
// front end: atom window, chain tracking and stride phase, pushes torsion windows
module das_front #(
  parameter int COORD_WIDTH = das_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           chain_start,
  input  logic signed [COORD_WIDTH-1:0]  coord_x,
  input  logic signed [COORD_WIDTH-1:0]  coord_y,
  input  logic signed [COORD_WIDTH-1:0]  coord_z,
  input  logic [das_pkg::STRIDE_W-1:0]   window_stride,
  input  logic                           q_full,
  output logic                           push,
  output logic [12*COORD_WIDTH-1:0]      push_data
);

  logic signed [COORD_WIDTH-1:0] wx [3];
  logic signed [COORD_WIDTH-1:0] wy [3];
  logic signed [COORD_WIDTH-1:0] wz [3];
  logic [1:0] atoms_seen;
  logic [das_pkg::STRIDE_W-1:0] stride_phase;

  logic accept;
  logic [1:0] seen_eff;
  logic [das_pkg::STRIDE_W-1:0] phase_eff;
  logic [das_pkg::STRIDE_W-1:0] stride;
  logic [das_pkg::STRIDE_W:0] phase_inc;
  logic [das_pkg::STRIDE_W-1:0] phase_next;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // chain start empties the window before the atom is taken
  always_comb begin
    seen_eff   = chain_start ? 2'd0 : atoms_seen;
    phase_eff  = chain_start ? '0 : stride_phase;
    stride     = (window_stride == '0) ? das_pkg::STRIDE_W'(1) : window_stride;
    phase_inc  = {1'b0, phase_eff} + 1'b1;
    phase_next = (phase_inc >= {1'b0, stride}) ? '0 : phase_inc[das_pkg::STRIDE_W-1:0];
  end

  // window of four points goes to the queue
  assign push = accept && (seen_eff == 2'd3) && (phase_eff == '0);
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      push_data[(3*k+0)*COORD_WIDTH +: COORD_WIDTH] = wx[k];
      push_data[(3*k+1)*COORD_WIDTH +: COORD_WIDTH] = wy[k];
      push_data[(3*k+2)*COORD_WIDTH +: COORD_WIDTH] = wz[k];
    end
    push_data[9*COORD_WIDTH +: COORD_WIDTH]  = coord_x;
    push_data[10*COORD_WIDTH +: COORD_WIDTH] = coord_y;
    push_data[11*COORD_WIDTH +: COORD_WIDTH] = coord_z;
  end

  // window shift and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      atoms_seen   <= 2'd0;
      stride_phase <= '0;
    end else if (accept) begin
      atoms_seen   <= (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;
      stride_phase <= (seen_eff == 2'd3) ? phase_next : phase_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wx[0] <= wx[1];
      wy[0] <= wy[1];
      wz[0] <= wz[1];
      wx[1] <= wx[2];
      wy[1] <= wy[2];
      wz[1] <= wz[2];
      wx[2] <= coord_x;
      wy[2] <= coord_y;
      wz[2] <= coord_z;
    end
  end

endmodule

// ===== rtl/das_queue.sv =====
// two-entry queue between the window front end and the angle engine
module das_queue #(
  parameter int DATA_W = 12 * das_pkg::COORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0] mem [2];
  logic [1:0] count;
  logic wr_ptr;
  logic rd_ptr;
  logic do_push;
  logic do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

// ===== rtl/das_back.sv =====
// angle engine: differences, normals and dot products on one shared multiplier, then square root and cordic
module das_back #(
  parameter int COORD_WIDTH     = das_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = das_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  logic [12*COORD_WIDTH-1:0]           item_data,
  output logic                                item_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [das_pkg::OUT_W-1:0]    twist_angle,
  output logic                                degenerate
);

  localparam int DW     = COORD_WIDTH + 1;
  localparam int RND_SH = das_pkg::QDEG - ANGLE_FRAC_BITS;
  localparam das_pkg::ang_t RND_HALF = 32'sd1 <<< (RND_SH - 1);
  localparam das_pkg::ang_t Z180     = 32'sd180 <<< das_pkg::QDEG;
  localparam das_pkg::ang_t Z90      = 32'sd90 <<< das_pkg::QDEG;
  localparam das_pkg::ang_t A_MAX    = 32'sd32767;
  localparam logic [4:0] N_UV   = 5'd12;
  localparam logic [4:0] N_XW   = 5'd12;
  localparam logic [4:0] N_NN   = 5'd3;
  localparam logic [4:0] LAST_I = 5'(das_pkg::CORDIC_STEPS - 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_DSH  = 12'b0000_0000_0010,
    S_MU   = 12'b0000_0000_0100,
    S_USH  = 12'b0000_0000_1000,
    S_MX   = 12'b0000_0001_0000,
    S_WSH  = 12'b0000_0010_0000,
    S_MY   = 12'b0000_0100_0000,
    S_SQRT = 12'b0000_1000_0000,
    S_PSH  = 12'b0001_0000_0000,
    S_SWAP = 12'b0010_0000_0000,
    S_CORD = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    K_U1, K_U2, K_X, K_W, K_NEG, K_NN
  } kind_t;

  state_t state;
  logic [4:0] cnt;

  logic signed [DW-1:0] d0 [3];
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];
  das_pkg::wide_t u1 [3];
  das_pkg::wide_t u2 [3];
  das_pkg::wide_t w [3];
  das_pkg::wide_t xv;
  das_pkg::wide_t yv;
  das_pkg::wide_t acc;
  logic neg_r;
  logic degen_r;
  logic [das_pkg::WIDE_W-1:0] sq_n;
  logic [das_pkg::WIDE_W-1:0] sq_r;
  logic [das_pkg::WIDE_W-1:0] sq_b;
  das_pkg::crd_t cx;
  das_pkg::crd_t cy;
  das_pkg::ang_t z;

  // multiplier issue and product stage
  das_pkg::mul_t a_op;
  das_pkg::mul_t b_op;
  logic issue;
  logic d_first;
  logic d_neg;
  logic d_last;
  kind_t d_kind;
  logic [1:0] d_comp;
  das_pkg::wide_t prod;
  logic pv;
  logic p_first;
  logic p_neg;
  logic p_last;
  kind_t p_kind;
  logic [1:0] p_comp;
  das_pkg::wide_t sum;

  function automatic logic [1:0] nxt3(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic logic [1:0] prv3(input logic [1:0] c);
    return (c == 2'd0) ? 2'd2 : c - 2'd1;
  endfunction

  function automatic das_pkg::mul_t pickd(input logic signed [DW-1:0] v0,
                                          input logic signed [DW-1:0] v1,
                                          input logic signed [DW-1:0] v2,
                                          input logic [1:0] s);
    das_pkg::mul_t r;
    unique case (s)
      2'd0:    r = das_pkg::MUL_W'(v0);
      2'd1:    r = das_pkg::MUL_W'(v1);
      default: r = das_pkg::MUL_W'(v2);
    endcase
    return r;
  endfunction

  function automatic das_pkg::mul_t pickw(input das_pkg::wide_t v0,
                                          input das_pkg::wide_t v1,
                                          input das_pkg::wide_t v2,
                                          input logic [1:0] s);
    das_pkg::mul_t r;
    unique case (s)
      2'd0:    r = das_pkg::MUL_W'(v0);
      2'd1:    r = das_pkg::MUL_W'(v1);
      default: r = das_pkg::MUL_W'(v2);
    endcase
    return r;
  endfunction

  function automatic logic big_w(input das_pkg::wide_t v);
    return (v >= das_pkg::MAG_LIM) || (v <= -das_pkg::MAG_LIM);
  endfunction

  function automatic logic big_d(input logic signed [DW-1:0] v);
    return big_w(das_pkg::WIDE_W'(v));
  endfunction

  // operand selection for the product schedule of each multiply phase
  always_comb begin
    logic [4:0] r;
    logic [1:0] c;
    logic [1:0] ai;
    logic [1:0] bi;
    logic term;
    r       = 5'd0;
    c       = 2'd0;
    ai      = 2'd0;
    bi      = 2'd0;
    term    = 1'b0;
    a_op    = '0;
    b_op    = '0;
    issue   = 1'b0;
    d_first = 1'b0;
    d_neg   = 1'b0;
    d_last  = 1'b0;
    d_kind  = K_X;
    d_comp  = 2'd0;
    if (state == S_MU && cnt < N_UV) begin
      issue   = 1'b1;
      r       = (cnt >= 5'd6) ? cnt - 5'd6 : cnt;
      c       = r[2:1];
      term    = r[0];
      ai      = term ? prv3(c) : nxt3(c);
      bi      = term ? nxt3(c) : prv3(c);
      d_first = !term;
      d_neg   = term;
      d_last  = term;
      d_comp  = c;
      if (cnt < 5'd6) begin
        a_op   = pickd(d0[0], d0[1], d0[2], ai);
        b_op   = pickd(d1[0], d1[1], d1[2], bi);
        d_kind = K_U1;
      end else begin
        a_op   = pickd(d1[0], d1[1], d1[2], ai);
        b_op   = pickd(d2[0], d2[1], d2[2], bi);
        d_kind = K_U2;
      end
    end else if (state == S_MX && cnt < N_XW) begin
      issue = 1'b1;
      if (cnt < 5'd3) begin
        c       = cnt[1:0];
        a_op    = pickw(u1[0], u1[1], u1[2], c);
        b_op    = pickw(u2[0], u2[1], u2[2], c);
        d_first = (c == 2'd0);
        d_last  = (c == 2'd2);
        d_kind  = K_X;
      end else if (cnt < 5'd9) begin
        r       = cnt - 5'd3;
        c       = r[2:1];
        term    = r[0];
        ai      = term ? prv3(c) : nxt3(c);
        bi      = term ? nxt3(c) : prv3(c);
        a_op    = pickw(u1[0], u1[1], u1[2], ai);
        b_op    = pickw(u2[0], u2[1], u2[2], bi);
        d_first = !term;
        d_neg   = term;
        d_last  = term;
        d_comp  = c;
        d_kind  = K_W;
      end else begin
        r       = cnt - 5'd9;
        c       = r[1:0];
        a_op    = pickw(u1[0], u1[1], u1[2], c);
        b_op    = pickd(d2[0], d2[1], d2[2], c);
        d_first = (c == 2'd0);
        d_last  = (c == 2'd2);
        d_kind  = K_NEG;
      end
    end else if (state == S_MY && cnt < N_NN) begin
      issue   = 1'b1;
      c       = cnt[1:0];
      a_op    = pickw(w[0], w[1], w[2], c);
      b_op    = pickw(w[0], w[1], w[2], c);
      d_first = (c == 2'd0);
      d_last  = (c == 2'd2);
      d_kind  = K_NN;
    end
  end

  // accumulate stage
  assign sum = (p_first ? das_pkg::wide_t'(0) : acc) + (p_neg ? -prod : prod);

  // shift tests
  logic d_big;
  logic u1_big;
  logic u2_big;
  logic w_big;
  logic u1_zero;
  logic u2_zero;
  always_comb begin
    d_big   = 1'b0;
    u1_big  = 1'b0;
    u2_big  = 1'b0;
    w_big   = 1'b0;
    for (int c = 0; c < 3; c++) begin
      d_big  = d_big | big_d(d0[c]) | big_d(d1[c]) | big_d(d2[c]);
      u1_big = u1_big | big_w(u1[c]);
      u2_big = u2_big | big_w(u2[c]);
      w_big  = w_big | big_w(w[c]);
    end
    u1_zero = (u1[0] == '0) && (u1[1] == '0) && (u1[2] == '0);
    u2_zero = (u2[0] == '0) && (u2[1] == '0) && (u2[2] == '0);
  end

  // one square root step
  logic [das_pkg::WIDE_W-1:0] sq_rb;
  logic [das_pkg::WIDE_W-1:0] sq_n_next;
  logic [das_pkg::WIDE_W-1:0] sq_r_next;
  always_comb begin
    sq_rb = sq_r + sq_b;
    if (sq_n >= sq_rb) begin
      sq_n_next = sq_n - sq_rb;
      sq_r_next = (sq_r >> 1) + sq_b;
    end else begin
      sq_n_next = sq_n;
      sq_r_next = sq_r >> 1;
    end
  end

  // one cordic vectoring step
  das_pkg::crd_t cx_next;
  das_pkg::crd_t cy_next;
  das_pkg::ang_t z_next;
  always_comb begin
    if (cy > 0) begin
      cx_next = cx + (cy >>> cnt);
      cy_next = cy - (cx >>> cnt);
      z_next  = z + das_pkg::atan_q20(cnt);
    end else begin
      cx_next = cx - (cy >>> cnt);
      cy_next = cy + (cx >>> cnt);
      z_next  = z - das_pkg::atan_q20(cnt);
    end
  end

  // clamp, round and sign of the result
  das_pkg::ang_t zc;
  das_pkg::ang_t a_full;
  logic signed [das_pkg::OUT_W-1:0] a16;
  logic signed [das_pkg::OUT_W-1:0] angle_final;
  always_comb begin
    if (z < 0) begin
      zc = '0;
    end else if (z > Z180) begin
      zc = Z180;
    end else begin
      zc = z;
    end
    a_full = (zc + RND_HALF) >>> RND_SH;
    a16    = (a_full > A_MAX) ? das_pkg::OUT_W'(A_MAX) : das_pkg::OUT_W'(a_full);
    if (degen_r) begin
      angle_final = '0;
    end else begin
      angle_final = neg_r ? -a16 : a16;
    end
  end

  assign item_pop = (state == S_IDLE) && item_valid;

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pv      <= issue;
      prod    <= a_op * b_op;
      p_first <= d_first;
      p_neg   <= d_neg;
      p_last  <= d_last;
      p_kind  <= d_kind;
      p_comp  <= d_comp;
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            for (int c = 0; c < 3; c++) begin
              d0[c] <= DW'(signed'(item_data[(3+c)*COORD_WIDTH +: COORD_WIDTH]))
                     - DW'(signed'(item_data[c*COORD_WIDTH +: COORD_WIDTH]));
              d1[c] <= DW'(signed'(item_data[(6+c)*COORD_WIDTH +: COORD_WIDTH]))
                     - DW'(signed'(item_data[(3+c)*COORD_WIDTH +: COORD_WIDTH]));
              d2[c] <= DW'(signed'(item_data[(9+c)*COORD_WIDTH +: COORD_WIDTH]))
                     - DW'(signed'(item_data[(6+c)*COORD_WIDTH +: COORD_WIDTH]));
            end
            degen_r <= 1'b0;
            state   <= S_DSH;
          end
        end
        S_DSH: begin
          if (d_big) begin
            for (int c = 0; c < 3; c++) begin
              d0[c] <= d0[c] >>> 1;
              d1[c] <= d1[c] >>> 1;
              d2[c] <= d2[c] >>> 1;
            end
          end else begin
            cnt   <= '0;
            state <= S_MU;
          end
        end
        S_MU: begin
          if (cnt == N_UV + 5'd1) begin
            cnt <= '0;
            if (u1_zero || u2_zero) begin
              degen_r <= 1'b1;
              state   <= S_DONE;
            end else begin
              state <= S_USH;
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_USH: begin
          for (int c = 0; c < 3; c++) begin
            if (u1_big) u1[c] <= u1[c] >>> 1;
            if (u2_big) u2[c] <= u2[c] >>> 1;
          end
          if (!u1_big && !u2_big) begin
            cnt   <= '0;
            state <= S_MX;
          end
        end
        S_MX: begin
          if (cnt == N_XW + 5'd1) begin
            cnt   <= '0;
            state <= S_WSH;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_WSH: begin
          if (w_big) begin
            for (int c = 0; c < 3; c++) w[c] <= w[c] >>> 1;
            xv <= xv >>> 1;
          end else begin
            cnt   <= '0;
            state <= S_MY;
          end
        end
        S_MY: begin
          if (cnt == N_NN + 5'd1) begin
            cnt   <= '0;
            sq_r  <= '0;
            sq_b  <= 64'd1 << 62;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_SQRT: begin
          sq_n <= sq_n_next;
          sq_r <= sq_r_next;
          sq_b <= sq_b >> 2;
          if (sq_b == 64'd1) begin
            yv    <= das_pkg::wide_t'(sq_r_next);
            state <= S_PSH;
          end
        end
        S_PSH: begin
          if (big_w(xv) || big_w(yv)) begin
            xv <= xv >>> 1;
            yv <= yv >>> 1;
          end else begin
            state <= S_SWAP;
          end
        end
        S_SWAP: begin
          if (xv < 0) begin
            cx <= das_pkg::CRD_W'(yv);
            cy <= das_pkg::CRD_W'(-xv);
            z  <= Z90;
          end else begin
            cx <= das_pkg::CRD_W'(xv);
            cy <= das_pkg::CRD_W'(yv);
            z  <= '0;
          end
          cnt   <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          cx <= cx_next;
          cy <= cy_next;
          z  <= z_next;
          if (cnt == LAST_I) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            twist_angle <= angle_final;
            degenerate  <= degen_r;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // product write back
      if (pv) begin
        acc <= sum;
        if (p_last) begin
          unique case (p_kind)
            K_U1:    u1[p_comp] <= sum;
            K_U2:    u2[p_comp] <= sum;
            K_X:     xv <= sum;
            K_W:     w[p_comp] <= sum;
            K_NEG:   neg_r <= sum[das_pkg::WIDE_W-1];
            K_NN:    sq_n <= sum;
            default: ;
          endcase
        end
      end
    end
  end

  // a degenerate window always reports a zero angle
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (twist_angle == '0))
    else $error("degenerate item with nonzero angle");

  // a new result comes only from the final state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the final state");

  // cordic step index stays inside the table
  a_cord_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORD) |-> (cnt < 5'(das_pkg::CORDIC_STEPS)))
    else $error("cordic step index out of range");

  // square root bit never runs out before the last step
  a_sqrt_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT) |-> (sq_b != '0))
    else $error("square root ran past its last step");

endmodule

// ===== rtl/dihedral_angle_stream.sv =====
// top level of the dihedral angle stream: register port, front end, queue and angle engine
//
// Atoms enter on the in channel (in_valid/in_ready) with chain_start and
// signed x/y/z coordinates; torsion results leave on the out channel
// (out_valid/out_ready) as twist_angle and degenerate.
// window_stride is written over the APB-style port at byte address 0.
// An atom that completes no emitted window is taken back to back, as long
// as the two-entry window queue is not full.
// Each emitted window is worked by one engine around a single 32x32
// multiplier, through the 12+12+3 multiply schedule, the 32-step square
// root and the 27 cordic steps, plus the normalizing shifts (one bit per
// cycle) that wide coordinates need; the engine takes the next window
// only from its idle state. A finished result waits in the output register
// while the engine goes on with the next window; if the receiver stalls,
// the engine holds in its final state and then the queue fills and in_ready
// drops. Reset empties the queue, clears the chain counters, drops out_valid
// and sets window_stride to 1.
module dihedral_angle_stream #(
  parameter int COORD_WIDTH     = das_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = das_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [das_pkg::APB_AW-1:0]         paddr,
  input  logic [das_pkg::APB_DW-1:0]         pwdata,
  output logic [das_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               chain_start,
  input  logic signed [COORD_WIDTH-1:0]      coord_x,
  input  logic signed [COORD_WIDTH-1:0]      coord_y,
  input  logic signed [COORD_WIDTH-1:0]      coord_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [das_pkg::OUT_W-1:0]   twist_angle,
  output logic                               degenerate
);

  localparam int ITEM_W = 12 * COORD_WIDTH;

  logic [das_pkg::STRIDE_W-1:0] window_stride;
  logic cfg_wr;
  logic q_push;
  logic [ITEM_W-1:0] q_push_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  logic [ITEM_W-1:0] q_data;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_stride <= das_pkg::STRIDE_RESET;
    end else if (cfg_wr && (paddr[2] == das_pkg::REG_WINDOW_STRIDE)) begin
      window_stride <= pwdata[das_pkg::STRIDE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == das_pkg::REG_WINDOW_STRIDE)
                ? das_pkg::APB_DW'(window_stride) : '0;

  // window tracking
  das_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .chain_start   (chain_start),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .window_stride (window_stride),
    .q_full        (q_full),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  // window queue
  das_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  // angle engine
  das_back #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (q_valid),
    .item_data   (q_data),
    .item_pop    (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .twist_angle (twist_angle),
    .degenerate  (degenerate)
  );

endmodule

// ===== dv/das_torsion_checker.sv =====
// torsion angle predictor and result checker for the dihedral angle stream
`timescale 1ns / 1ps

module das_torsion_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [das_pkg::APB_AW-1:0]             paddr,
  input  logic [das_pkg::APB_DW-1:0]             pwdata,
  input  logic                                   pready,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   chain_start,
  input  logic signed [23:0]                     coord_x,
  input  logic signed [23:0]                     coord_y,
  input  logic signed [23:0]                     coord_z,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic signed [das_pkg::OUT_W-1:0]       twist_angle,
  input  logic                                   degenerate,
  output int                                     fail_count,
  output int                                     pending
);

  typedef struct packed {
    logic signed [15:0] angle;
    logic               degen;
  } torsion_t;

  typedef longint vec3_t [3];

  localparam longint ARC_Q20 [27] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
    458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  torsion_t       expected_torsions [$];
  longint         atom_x [3], atom_y [3], atom_z [3];
  int unsigned    chain_len, window_phase;
  logic [3:0]     stride_reg;

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic int norm_shift(longint unsigned m);
    int s;
    s = 0;
    while ((m >> s) >= 64'd1 << 30) s++;
    return s;
  endfunction

  function automatic longint unsigned peak(vec3_t v);
    longint unsigned m;
    m = 0;
    for (int c = 0; c < 3; c++) if (magn(v[c]) > m) m = magn(v[c]);
    return m;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic longint dot3(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // exact fixed point torsion of one four atom window
  function automatic torsion_t torsion_of(longint px [4], longint py [4], longint pz [4]);
    vec3_t d1, d2, d3, u1, u2, w;
    longint unsigned m;
    longint x, y, z, nx, ny, a;
    int s, sw;
    logic neg;
    torsion_t r;
    d1 = '{px[1] - px[0], py[1] - py[0], pz[1] - pz[0]};
    d2 = '{px[2] - px[1], py[2] - py[1], pz[2] - pz[1]};
    d3 = '{px[3] - px[2], py[3] - py[2], pz[3] - pz[2]};
    m = peak(d1);
    if (peak(d2) > m) m = peak(d2);
    if (peak(d3) > m) m = peak(d3);
    s = norm_shift(m);
    for (int c = 0; c < 3; c++) begin
      d1[c] = d1[c] >>> s;
      d2[c] = d2[c] >>> s;
      d3[c] = d3[c] >>> s;
    end
    u1 = cross3(d1, d2);
    u2 = cross3(d2, d3);
    if (peak(u1) == 0 || peak(u2) == 0) begin
      r.angle = '0;
      r.degen = 1'b1;
      return r;
    end
    s = norm_shift(peak(u1));
    for (int c = 0; c < 3; c++) u1[c] = u1[c] >>> s;
    s = norm_shift(peak(u2));
    for (int c = 0; c < 3; c++) u2[c] = u2[c] >>> s;
    x = dot3(u1, u2);
    w = cross3(u1, u2);
    sw = norm_shift(peak(w));
    for (int c = 0; c < 3; c++) w[c] = w[c] >>> sw;
    y = longint'(int_sqrt(dot3(w, w)));
    x = x >>> sw;
    neg = dot3(u1, d3) < 0;
    m = magn(x) > y ? magn(x) : y;
    s = norm_shift(m);
    x = x >>> s;
    y = y >>> s;
    z = 0;
    // fold the left half plane so cordic converges
    if (x < 0) begin
      nx = y;
      y = -x;
      x = nx;
      z = 64'sd90 << 20;
    end
    for (int i = 0; i < 27; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ARC_Q20[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ARC_Q20[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > (64'sd180 << 20)) z = 64'sd180 << 20;
    a = (z + (64'sd1 << 12)) >>> 13;
    if (a > 32767) a = 32767;
    if (neg) a = -a;
    r.angle = a[15:0];
    r.degen = 1'b0;
    return r;
  endfunction

  assign pending = expected_torsions.size();

  // track register writes and atoms, predict results
  always @(posedge clk) begin
    longint px [4], py [4], pz [4];
    int unsigned eff_stride;
    torsion_t got, want;
    if (rst) begin
      expected_torsions.delete();
      atom_x = '{0, 0, 0};
      atom_y = '{0, 0, 0};
      atom_z = '{0, 0, 0};
      chain_len <= 0;
      window_phase <= 0;
      stride_reg <= das_pkg::STRIDE_RESET;
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == das_pkg::REG_WINDOW_STRIDE)
        stride_reg <= pwdata[3:0];
      if (in_valid && in_ready) begin
        int unsigned len, ph;
        len = chain_start ? 0 : chain_len;
        ph = chain_start ? 0 : window_phase;
        if (len >= 3) begin
          eff_stride = stride_reg == 0 ? 1 : stride_reg;
          if (ph == 0) begin
            for (int k = 0; k < 3; k++) begin
              px[k] = atom_x[k];
              py[k] = atom_y[k];
              pz[k] = atom_z[k];
            end
            px[3] = coord_x;
            py[3] = coord_y;
            pz[3] = coord_z;
            expected_torsions = {expected_torsions, torsion_of(px, py, pz)};
          end
          ph = (ph + 1 >= eff_stride) ? 0 : ph + 1;
        end
        atom_x = '{atom_x[1], atom_x[2], longint'(coord_x)};
        atom_y = '{atom_y[1], atom_y[2], longint'(coord_y)};
        atom_z = '{atom_z[1], atom_z[2], longint'(coord_z)};
        chain_len <= len < 3 ? len + 1 : 3;
        window_phase <= ph;
      end
      // compare each result with the oldest prediction
      if (out_valid && out_ready) begin
        got.angle = twist_angle;
        got.degen = degenerate;
        if (expected_torsions.size() == 0) begin
          $display("%0t: unexpected result angle %0d degenerate %0b",
                   $time, got.angle, got.degen);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_torsions.pop_front();
          if (got.angle !== want.angle || got.degen !== want.degen) begin
            $display("%0t: mismatch expected angle %0d degenerate %0b, actual angle %0d degenerate %0b",
                     $time, want.angle, want.degen, got.angle, got.degen);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/dihedral_angle_stream_test.sv =====
// stimulus and verdict for the dihedral angle stream
`timescale 1ns / 1ps

module dihedral_angle_stream_test;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 250;
  localparam logic signed [23:0] CMAX = 24'sd8388607;
  localparam logic signed [23:0] CMIN = -24'sd8388608;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [das_pkg::APB_AW-1:0] paddr = '0;
  logic [das_pkg::APB_DW-1:0] pwdata = '0;
  logic [das_pkg::APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic chain_start = 1'b0;
  logic signed [23:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [das_pkg::OUT_W-1:0] twist_angle;
  logic degenerate;
  int fail_count, pending;
  int stall_cycles = 0;
  logic calm = 1'b0;
  logic signed [23:0] walk_x = '0, walk_y = '0, walk_z = '0;

  always #5 clk = ~clk;

  dihedral_angle_stream uut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .chain_start, .coord_x, .coord_y, .coord_z,
    .out_valid, .out_ready, .twist_angle, .degenerate
  );

  das_torsion_checker chk (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_ready, .chain_start, .coord_x, .coord_y, .coord_z,
    .out_valid, .out_ready, .twist_angle, .degenerate, .fail_count, .pending
  );

  // receiver back pressure
  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 24);

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || rst)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("dihedral_angle_stream_test failed");
      $finish;
    end
  end

  task automatic send_atom(input logic cs, input logic signed [23:0] x, y, z);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    chain_start <= cs;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // let every pending result drain, then allow the engine to settle
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [das_pkg::APB_AW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // random chains: mostly bonded walks, some full range atoms
  task automatic random_chains(input int n_atoms);
    int left, run;
    logic cs;
    logic signed [23:0] x, y, z;
    left = n_atoms;
    while (left > 0) begin
      run = $urandom_range(1, 40);
      for (int k = 0; k < run && left > 0; k++, left--) begin
        cs = (k == 0) || ($urandom_range(99) < 2);
        if ($urandom_range(99) < 15) begin
          x = 24'($urandom);
          y = 24'($urandom);
          z = 24'($urandom);
        end else if ($urandom_range(99) < 4) begin
          x = walk_x;
          y = walk_y;
          z = walk_z;
        end else begin
          x = walk_x + $signed(24'($urandom_range(4000))) - 24'sd2000;
          y = walk_y + $signed(24'($urandom_range(4000))) - 24'sd2000;
          z = walk_z + $signed(24'($urandom_range(4000))) - 24'sd2000;
        end
        walk_x = x;
        walk_y = y;
        walk_z = z;
        send_atom(cs, x, y, z);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short chain then a fresh one
    send_atom(1, 0, 0, 0);
    send_atom(0, 1536, 0, 0);
    send_atom(0, 1536, 1536, 0);
    // cis, then positive and negative ninety degree torsions
    send_atom(1, 0, 0, 0);
    send_atom(0, 1536, 0, 0);
    send_atom(0, 1536, 1536, 0);
    send_atom(0, 0, 1536, 0);
    send_atom(0, 0, 1536, 1536);
    send_atom(0, 0, 0, 1536);
    send_atom(0, -1536, 0, 1536);
    // collinear and repeated atoms give a zero normal
    send_atom(1, 0, 0, 0);
    send_atom(0, 100, 100, 100);
    send_atom(0, 200, 200, 200);
    send_atom(0, 200, 200, 200);
    send_atom(0, 5, -7, 9);
    // full scale corners
    send_atom(1, CMIN, CMIN, CMIN);
    send_atom(0, CMAX, CMIN, CMIN);
    send_atom(0, CMAX, CMAX, CMIN);
    send_atom(0, CMAX, CMAX, CMAX);
    send_atom(0, CMIN, CMAX, CMAX);
    send_atom(0, CMIN, CMIN, CMAX);
    send_atom(0, -24'sd1, 24'sd1, -24'sd1);
    drain;

    // default stride with a calm stretch
    calm <= 1'b1;
    random_chains(90);
    calm <= 1'b0;
    random_chains(40);
    drain;

    // largest stride
    write_reg(3'd0, 32'd15);
    random_chains(120);
    drain;

    // zero stride acts as one; the unused address must be ignored
    write_reg(3'd0, 32'd0);
    write_reg(3'd4, 32'd7);
    random_chains(100);
    drain;

    write_reg(3'd0, 32'd3);
    random_chains(100);
    drain;

    write_reg(3'd0, 32'd1);
    random_chains(100);
    drain;

    if (fail_count == 0 && pending == 0) begin
      $display("dihedral_angle_stream_test passed");
    end else begin
      $display("dihedral_angle_stream_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/das_pkg.sv
rtl/das_front.sv
rtl/das_queue.sv
rtl/das_back.sv
rtl/dihedral_angle_stream.sv
dv/das_torsion_checker.sv
dv/dihedral_angle_stream_test.sv
